@@ sv/pidaw_pkg.sv @@
// pidaw_pkg: shared types and constants for the PID controller with anti-windup.
// Depends on nothing.
package pidaw_pkg;

    localparam int FRAC_BITS_DEF        = 16;
    localparam int INTEGRATOR_WIDTH_DEF = 48;
    localparam int DATA_W               = 32;
    localparam int CFG_IDX_W            = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd5;

    localparam logic [DATA_W-1:0] OUT_MAX_RESET = 32'd16711680;

    // serial unit command/status
    typedef struct packed {
        logic start;
    } ser_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ser_sts_t;

endpackage

@@ sv/pidaw_mul.sv @@
// pidaw_mul: bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on pidaw_pkg.
module pidaw_mul
    import pidaw_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ser_ctl_t            ctl,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output ser_sts_t            sts,
    output logic signed [AW+BW-1:0] prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] addend;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        addend      = mcand_reg;
        if (ctl.start)
        begin
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // top multiplier bit carries negative weight
            if (cnt_reg == CW'(BW - 1))
                addend = ~mcand_reg + PW'(1);
            if (mplier_reg[0])
                acc_next = acc_reg + addend;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CW'(1);
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign prod     = acc_reg;

endmodule

@@ sv/pidaw_div.sv @@
// pidaw_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on pidaw_pkg.
module pidaw_div
    import pidaw_pkg::*;
#(
    parameter int NW = 128,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ser_ctl_t      ctl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output ser_sts_t      sts,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[NW-1]};
        if (ctl.start)
        begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, den_reg})
            begin
                rem_next = (DW+1)'(trial - {2'b00, den_reg});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = q_reg;

endmodule

@@ sv/pid_controller_antiwindup.sv @@
// pid_controller_antiwindup: top level of the fixed-point PID controller.
// Depends on pidaw_pkg, pidaw_mul and pidaw_div.
//
// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tdata[31:0] measured
// m_axis    | out | m_axis_tvalid/tready    | tdata[31:0] drive; tuser[0] clamped_high,
//           |     |                         | tuser[1] clamped_low
// cfg       | in  | cfg_we                  | cfg_idx, cfg_data
//
// One request at a time. A single bit-serial multiplier forms the three
// products in turn; a clamped result, when the integral gain is nonzero,
// adds a restoring divide for the anti-windup pull-back of the integrator.
// Reset (rst_n, async low) clears control, integrator and previous error.
// The result sits in an output register; the next sample is taken once it
// leaves, so a stalled m_axis holds s_axis_tready low.
module pid_controller_antiwindup
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int INTEGRATOR_WIDTH = INTEGRATOR_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] measured
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] drive
    output logic [1:0]           m_axis_tuser,   // [0] clamped_high, [1] clamped_low
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [DATA_W-1:0]    cfg_data
);
    localparam int IW = INTEGRATOR_WIDTH;
    localparam int MB = IW;              // multiplier operand width (holds err, diff, integ)
    localparam int PW = DATA_W + MB;     // product width
    localparam int SW = PW + 2;          // sum of three products
    localparam int NW = SW + FRAC_BITS;  // pull-back numerator

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MULP  = 7'b0000010,
        ST_MULI  = 7'b0000100,
        ST_MULD  = 7'b0001000,
        ST_CLAMP = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_W-1:0] out_min_reg, out_max_reg;
    logic signed [IW-1:0]     integ_reg, integ_next;
    logic signed [DATA_W-1:0] prev_err_reg, prev_err_next;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;
    logic                     hi_reg, hi_next, lo_reg, lo_next;
    // quotient sign, captured when the divide starts
    logic                     qneg_reg;

    ser_ctl_t                 mul_ctl, div_ctl;
    ser_sts_t                 mul_sts, div_sts;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;
    logic [NW-1:0]            div_num;
    logic [DATA_W-1:0]        div_den;
    logic [NW-1:0]            div_q;

    logic signed [DATA_W:0]   err_wide;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [IW:0]       integ_add;
    logic signed [IW-1:0]     integ_upd;
    logic signed [SW-1:0]     sum_sh;
    logic signed [SW-1:0]     excess;
    logic signed [NW-1:0]     num_s;
    logic signed [NW+1:0]     integ_sub;
    logic signed [NW+1:0]     q_signed;
    logic signed [NW+1:0]     imax_w, imin_w;

    localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

    pidaw_mul #(.AW(DATA_W), .BW(MB)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl(mul_ctl), .a(mul_a), .b(mul_b),
        .sts(mul_sts), .prod(mul_p)
    );

    pidaw_div #(.NW(NW), .DW(DATA_W)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .num(div_num), .den(div_den),
        .sts(div_sts), .quo(div_q)
    );

    // error and integrator update from the incoming sample
    assign err_wide  = (DATA_W+1)'(setpoint_reg) - (DATA_W+1)'($signed(s_axis_tdata));
    assign err_sat   = (err_wide[DATA_W] != err_wide[DATA_W-1])
                     ? (err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}})
                     : err_wide[DATA_W-1:0];
    assign integ_add = (IW+1)'(integ_reg) + (IW+1)'(err_sat);
    assign integ_upd = (integ_add[IW] != integ_add[IW-1])
                     ? (integ_add[IW] ? IMIN : IMAX) : integ_add[IW-1:0];

    // floor shift of the product sum
    assign sum_sh  = sum_reg >>> FRAC_BITS;
    assign excess  = hi_reg ? sum_reg - SW'(out_max_reg) : sum_reg - SW'(out_min_reg);
    assign num_s   = NW'(excess) <<< FRAC_BITS;
    assign div_num = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
    assign div_den = gain_i_reg[DATA_W-1] ? DATA_W'(-gain_i_reg) : DATA_W'(gain_i_reg);

    assign q_signed  = qneg_reg ? -(NW+2)'({2'b00, div_q}) : (NW+2)'({2'b00, div_q});
    assign integ_sub = (NW+2)'(integ_reg) - q_signed;
    assign imax_w    = (NW+2)'(IMAX);
    assign imin_w    = (NW+2)'(IMIN);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = drive_reg;
    assign m_axis_tuser  = {lo_reg, hi_reg};

    always_comb
    begin
        state_next    = state_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        err_next      = err_reg;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        drive_next    = drive_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        mul_ctl.start = 1'b0;
        div_ctl.start = 1'b0;
        mul_a         = gain_p_reg;
        mul_b         = MB'(err_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    err_next      = err_sat;
                    integ_next    = integ_upd;
                    sum_next      = '0;
                    mul_ctl.start = 1'b1;
                    mul_a         = gain_p_reg;
                    mul_b         = MB'(err_sat);
                    state_next    = ST_MULP;
                end
            end
            ST_MULP:
            begin
                if (mul_sts.done)
                begin
                    sum_next      = sum_reg + SW'(mul_p);
                    mul_ctl.start = 1'b1;
                    mul_a         = gain_i_reg;
                    mul_b         = MB'(integ_reg);
                    state_next    = ST_MULI;
                end
            end
            ST_MULI:
            begin
                if (mul_sts.done)
                begin
                    sum_next      = sum_reg + SW'(mul_p);
                    mul_ctl.start = 1'b1;
                    mul_a         = gain_d_reg;
                    mul_b         = MB'(err_reg) - MB'(prev_err_reg);
                    state_next    = ST_MULD;
                end
            end
            ST_MULD:
            begin
                if (mul_sts.done)
                begin
                    sum_next      = sum_reg + SW'(mul_p);
                    prev_err_next = err_reg;
                    state_next    = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                sum_next = sum_sh;
                hi_next  = 1'b0;
                lo_next  = 1'b0;
                if (sum_sh > SW'(out_max_reg))
                begin
                    drive_next = out_max_reg;
                    hi_next    = 1'b1;
                end
                else if (sum_sh < SW'(out_min_reg))
                begin
                    drive_next = out_min_reg;
                    lo_next    = 1'b1;
                end
                else
                    drive_next = sum_sh[DATA_W-1:0];
                if ((hi_next || lo_next) && (gain_i_reg != '0))
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                // first cycle: sum_reg holds shifted sum; kick the divider
                if (!div_sts.busy && !div_sts.done && !neg_reg)
                begin
                    div_ctl.start = 1'b1;
                    neg_next      = 1'b1;
                end
                if (div_sts.done)
                begin
                    if (integ_sub > imax_w)
                        integ_next = IMAX;
                    else if (integ_sub < imin_w)
                        integ_next = IMIN;
                    else
                        integ_next = integ_sub[IW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_DIV && !div_sts.busy && !div_sts.done && !neg_reg)
            neg_next = 1'b1;
        if (state_reg == ST_CLAMP)
            neg_next = 1'b0;
        // a setpoint write restarts the integrator and the derivative history
        if (cfg_we && cfg_idx == REG_SETPOINT)
        begin
            integ_next    = '0;
            prev_err_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ctl.start)
            qneg_reg <= num_s[NW-1] ^ gain_i_reg[DATA_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            setpoint_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            out_min_reg  <= '0;
            out_max_reg  <= OUT_MAX_RESET;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            neg_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            neg_reg      <= neg_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_SETPOINT: setpoint_reg <= cfg_data;
                    REG_GAIN_P:   gain_p_reg   <= cfg_data;
                    REG_GAIN_I:   gain_i_reg   <= cfg_data;
                    REG_GAIN_D:   gain_d_reg   <= cfg_data;
                    REG_OUT_MIN:  out_min_reg  <= cfg_data;
                    REG_OUT_MAX:  out_max_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

endmodule
